@@ src/hadre_pkg.sv @@
// Shared types, constants and fixed-point helpers for the envelope core.
// Used by the interfaces, the register file, the update stage and the top level.
`timescale 1ns / 1ps
`default_nettype none

package hadre_pkg;

  localparam int FRAC_BITS = 23;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int GATE_W    = 8;
  localparam int TRIG_W    = 8;
  localparam int STAGE_W   = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [Q_W-1:0] Q_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [Q_W-1:0] Q_HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

  localparam int MODE_LOOP_BIT = 0;
  localparam int MODE_TRIG_BIT = 1;

  typedef enum logic [STAGE_W-1:0] {
    STAGE_HOLD    = 2'd0,
    STAGE_ATTACK  = 2'd1,
    STAGE_DECAY   = 2'd2,
    STAGE_RELEASE = 2'd3
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_STEP      = 3'd0,
    REG_ATTACK_STEP    = 3'd1,
    REG_DECAY_FACTOR   = 3'd2,
    REG_RELEASE_FACTOR = 3'd3,
    REG_SUSTAIN_LEVEL  = 3'd4,
    REG_RETRIG_MARGIN  = 3'd5,
    REG_MODE_BITS      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [Q_W-1:0]    hold_step;
    logic [Q_W-1:0]    attack_step;
    logic [Q_W-1:0]    decay_factor;
    logic [Q_W-1:0]    release_factor;
    logic [Q_W-1:0]    sustain_level;
    logic [Q_W-1:0]    retrig_margin;
    logic [MODE_W-1:0] mode_bits;
  } hadre_cfg_t;

  typedef struct packed {
    logic [Q_W-1:0] level;
    stage_t         stage;
  } hadre_result_t;

  // Clamp a register value to 1.0.
  function automatic logic [Q_W-1:0] qsat(input logic [Q_W-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

  // Truncating Q1.FRAC_BITS product; operands never exceed 1.0.
  function automatic logic [Q_W-1:0] qmul(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
    logic [2*Q_W-1:0] p;
    p = (2*Q_W)'(a) * (2*Q_W)'(b);
    return p[FRAC_BITS +: Q_W];
  endfunction

endpackage

`default_nettype wire

@@ src/hadre_tick_if.sv @@
// Input channel: one control tick carrying gate and trigger values.
// Depends on hadre_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hadre_tick_if
  import hadre_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [GATE_W-1:0] gate_value;
  logic [TRIG_W-1:0] trig_value;

  modport source (output valid, output gate_value, output trig_value, input ready);
  modport sink   (input valid, input gate_value, input trig_value, output ready);
endinterface

`default_nettype wire

@@ src/hadre_env_if.sv @@
// Output channel: envelope level and stage after each tick.
// Depends on hadre_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hadre_env_if
  import hadre_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [Q_W-1:0]     level;
  logic [STAGE_W-1:0] stage;

  modport source (output valid, output level, output stage, input ready);
  modport sink   (input valid, input level, input stage, output ready);
endinterface

`default_nettype wire

@@ src/hadre_cfg_regs.sv @@
// Configuration register file; Q-format values are clamped to 1.0 on write.
// Depends on hadre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hadre_cfg_regs
  import hadre_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [Q_W-1:0]       cfg_wdata,
  output hadre_cfg_t                cfg
);

  hadre_cfg_t regs;
  logic [Q_W-1:0] wdata_sat;

  assign wdata_sat = qsat(cfg_wdata);
  assign cfg       = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.hold_step      <= Q_ONE;
      regs.attack_step    <= Q_ONE;
      regs.decay_factor   <= '0;
      regs.release_factor <= '0;
      regs.sustain_level  <= Q_HALF;
      regs.retrig_margin  <= '0;
      regs.mode_bits      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_HOLD_STEP:      regs.hold_step      <= wdata_sat;
        REG_ATTACK_STEP:    regs.attack_step    <= wdata_sat;
        REG_DECAY_FACTOR:   regs.decay_factor   <= wdata_sat;
        REG_RELEASE_FACTOR: regs.release_factor <= wdata_sat;
        REG_SUSTAIN_LEVEL:  regs.sustain_level  <= wdata_sat;
        REG_RETRIG_MARGIN:  regs.retrig_margin  <= wdata_sat;
        REG_MODE_BITS:      regs.mode_bits      <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/hadre_update.sv @@
// Envelope state and its per-tick update: edge detection, stage machine,
// hold counter and level arithmetic. Depends on hadre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hadre_update
  import hadre_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              enable,
  input  wire logic [GATE_W-1:0] gate_value,
  input  wire logic [TRIG_W-1:0] trig_value,
  input  wire hadre_cfg_t        cfg,
  output hadre_result_t          result
);

  stage_t            cur_stage, stage_next, stage_sel;
  logic [Q_W-1:0]    env_level, env_level_next;
  logic [Q_W-1:0]    hold_count, hold_count_next;
  logic [GATE_W-1:0] last_gate;
  logic [TRIG_W-1:0] last_trig;

  logic           trig_change, gate_change;
  logic [Q_W-1:0] prod_rel, prod_sus, prod_lev, dec_level;
  logic [Q_W:0]   hold_sum, attack_sum, dec_sum, sus_limit;
  logic           hold_done, attack_over, loop_hit;

  assign trig_change = (trig_value != last_trig);
  assign gate_change = (gate_value != last_gate);

  // Stage after trigger and gate events, before the stage update.
  always_comb begin
    stage_sel = cur_stage;
    if (trig_change && cfg.mode_bits[MODE_TRIG_BIT]) begin
      stage_sel = STAGE_HOLD;
    end
    if (gate_change) begin
      stage_sel = (gate_value != '0) ? STAGE_HOLD : STAGE_RELEASE;
    end
  end

  assign prod_rel    = qmul(env_level, cfg.release_factor);
  assign prod_sus    = qmul(cfg.sustain_level, Q_ONE - cfg.decay_factor);
  assign prod_lev    = qmul(env_level, cfg.decay_factor);
  assign dec_sum     = {1'b0, prod_sus} + {1'b0, prod_lev};
  assign dec_level   = dec_sum[Q_W-1:0];
  assign hold_sum    = {1'b0, hold_count} + {1'b0, cfg.hold_step};
  assign attack_sum  = {1'b0, env_level} + {1'b0, cfg.attack_step};
  assign sus_limit   = {1'b0, cfg.sustain_level} + {1'b0, cfg.retrig_margin};
  assign hold_done   = (hold_sum > {1'b0, Q_ONE});
  assign attack_over = (attack_sum > {1'b0, Q_ONE});
  assign loop_hit    = ({1'b0, dec_level} < sus_limit) && cfg.mode_bits[MODE_LOOP_BIT];

  // Next stage.
  always_comb begin
    unique case (stage_sel)
      STAGE_HOLD:    stage_next = hold_done   ? STAGE_ATTACK : STAGE_HOLD;
      STAGE_ATTACK:  stage_next = attack_over ? STAGE_DECAY  : STAGE_ATTACK;
      STAGE_DECAY:   stage_next = loop_hit    ? STAGE_ATTACK : STAGE_DECAY;
      STAGE_RELEASE: stage_next = STAGE_RELEASE;
      default:       stage_next = STAGE_RELEASE;
    endcase
  end

  // Level and hold counter for the selected stage.
  always_comb begin
    env_level_next  = env_level;
    hold_count_next = hold_count;
    unique case (stage_sel)
      STAGE_HOLD: begin
        env_level_next  = prod_rel;
        hold_count_next = hold_done ? '0 : hold_sum[Q_W-1:0];
      end
      STAGE_ATTACK: begin
        env_level_next = attack_over ? Q_ONE : attack_sum[Q_W-1:0];
      end
      STAGE_DECAY: begin
        env_level_next = dec_level;
      end
      default: begin
        env_level_next  = prod_rel;
        hold_count_next = '0;
      end
    endcase
  end

  assign result.level = env_level_next;
  assign result.stage = stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_stage  <= STAGE_RELEASE;
      env_level  <= '0;
      hold_count <= '0;
      last_gate  <= '0;
      last_trig  <= '0;
    end else if (enable) begin
      cur_stage  <= stage_next;
      env_level  <= env_level_next;
      hold_count <= hold_count_next;
      last_gate  <= gate_value;
      last_trig  <= trig_value;
    end
  end

endmodule

`default_nettype wire

@@ src/hold_attack_decay_release_envelope_core.sv @@
// Hold-attack-decay-release envelope core: one level/stage result per control tick.
// Depends on hadre_pkg, hadre_tick_if, hadre_env_if, hadre_cfg_regs, hadre_update.
//
// A tick can be accepted every clock cycle unless the output stalls. A tick waits
// in an input register; when the output register is free or being taken, the
// envelope state is updated through the multipliers and adders in one pass and
// the result loaded into the output register, which holds it until taken while
// the next tick is accepted. The state feedback loop (stage, level, hold count)
// closes through that single pass, which sets that rate. Levels, steps and factors
// are unsigned Q1.23; register values above 1.0 are clamped on write. Configuration
// is to be written only while no tick is in flight; the core does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module hold_attack_decay_release_envelope_core
  import hadre_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [Q_W-1:0]       cfg_wdata,
  hadre_tick_if.sink                tick,
  hadre_env_if.source               env
);

  hadre_cfg_t    cfg;
  hadre_result_t result;

  logic              in_valid;
  logic [GATE_W-1:0] in_gate;
  logic [TRIG_W-1:0] in_trig;
  logic              out_valid;
  logic [Q_W-1:0]    out_level;
  stage_t            out_stage;
  logic              advance;

  hadre_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hadre_update u_update (
    .clk        (clk),
    .rst        (rst),
    .enable     (advance),
    .gate_value (in_gate),
    .trig_value (in_trig),
    .cfg        (cfg),
    .result     (result)
  );

  assign advance    = in_valid && (!out_valid || env.ready);
  assign tick.ready = !in_valid || advance;

  assign env.valid = out_valid;
  assign env.level = out_level;
  assign env.stage = STAGE_W'(out_stage);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      in_gate <= tick.gate_value;
      in_trig <= tick.trig_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (env.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_level <= result.level;
      out_stage <= result.stage;
    end
  end

endmodule

`default_nettype wire

@@ bench/hadre_envelope_checker.sv @@
// Envelope checker: watches the tick and envelope channels and the register port,
// predicts each tick's level and stage and compares them in order.
// Depends on hadre_pkg, hadre_tick_if and hadre_env_if.
`timescale 1ns / 1ps

module hadre_envelope_checker
  import hadre_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_wdata,
  hadre_tick_if                tick,
  hadre_env_if                 env,
  output int                   mismatch_count,
  output int                   pending_count,
  output int                   compared_count
);

  localparam logic [Q_W:0] UNITY = {1'b0, Q_ONE};

  hadre_cfg_t        regs_shadow;
  stage_t            stage_now;
  logic [Q_W:0]      level_now;
  logic [Q_W:0]      hold_acc;
  logic [GATE_W-1:0] gate_prev;
  logic [TRIG_W-1:0] trig_prev;
  hadre_result_t     envelope_due[$];
  hadre_result_t     tick_result;
  hadre_result_t     oldest;
  int                fail_tally;
  int                compared_tally;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    compared_count = 0;
    fail_tally     = 0;
    compared_tally = 0;
  end

  function automatic logic [Q_W:0] clip_unity(input logic [Q_W-1:0] v);
    return ({1'b0, v} > UNITY) ? UNITY : {1'b0, v};
  endfunction

  function automatic logic [Q_W:0] frac_mul(input logic [Q_W:0] a, input logic [Q_W:0] b);
    logic [2*Q_W+1:0] wide;
    wide = {{(Q_W+1){1'b0}}, a} * {{(Q_W+1){1'b0}}, b};
    return wide[FRAC_BITS +: Q_W+1];
  endfunction

  task automatic report_mismatch(input string msg);
    fail_tally++;
    $display("[%0t] envelope mismatch: %s", $time, msg);
  endtask

  task automatic advance_envelope(input logic [GATE_W-1:0] g, input logic [TRIG_W-1:0] t,
                                  output hadre_result_t r);
    logic [Q_W:0]   step_h;
    logic [Q_W:0]   step_a;
    logic [Q_W:0]   pole;
    logic [Q_W:0]   rel;
    logic [Q_W:0]   sus;
    logic [Q_W:0]   margin;
    logic [Q_W+1:0] floor_lvl;
    step_h = clip_unity(regs_shadow.hold_step);
    step_a = clip_unity(regs_shadow.attack_step);
    pole   = clip_unity(regs_shadow.decay_factor);
    rel    = clip_unity(regs_shadow.release_factor);
    sus    = clip_unity(regs_shadow.sustain_level);
    margin = clip_unity(regs_shadow.retrig_margin);

    // trigger first, then the gate decides the stage
    if (t != trig_prev) begin
      trig_prev = t;
      if (regs_shadow.mode_bits[MODE_TRIG_BIT]) stage_now = STAGE_HOLD;
    end
    if (g != gate_prev) begin
      gate_prev = g;
      stage_now = (g != '0) ? STAGE_HOLD : STAGE_RELEASE;
    end

    case (stage_now)
      STAGE_HOLD: begin
        hold_acc  = hold_acc + step_h;
        level_now = frac_mul(level_now, rel);
        if (hold_acc > UNITY) begin
          hold_acc  = '0;
          stage_now = STAGE_ATTACK;
        end
      end
      STAGE_ATTACK: begin
        level_now = level_now + step_a;
        if (level_now > UNITY) begin
          level_now = UNITY;
          stage_now = STAGE_DECAY;
        end
      end
      STAGE_DECAY: begin
        level_now = frac_mul(sus, UNITY - pole) + frac_mul(level_now, pole);
        floor_lvl = {1'b0, sus} + {1'b0, margin};
        if ({1'b0, level_now} < floor_lvl && regs_shadow.mode_bits[MODE_LOOP_BIT])
          stage_now = STAGE_ATTACK;
      end
      default: begin
        level_now = frac_mul(level_now, rel);
        hold_acc  = '0;
      end
    endcase

    r.level = level_now[Q_W-1:0];
    r.stage = stage_now;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs_shadow.hold_step      = Q_ONE;
      regs_shadow.attack_step    = Q_ONE;
      regs_shadow.decay_factor   = '0;
      regs_shadow.release_factor = '0;
      regs_shadow.sustain_level  = Q_HALF;
      regs_shadow.retrig_margin  = '0;
      regs_shadow.mode_bits      = '0;
      stage_now = STAGE_RELEASE;
      level_now = '0;
      hold_acc  = '0;
      gate_prev = '0;
      trig_prev = '0;
      envelope_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HOLD_STEP:      regs_shadow.hold_step      = cfg_wdata;
          REG_ATTACK_STEP:    regs_shadow.attack_step    = cfg_wdata;
          REG_DECAY_FACTOR:   regs_shadow.decay_factor   = cfg_wdata;
          REG_RELEASE_FACTOR: regs_shadow.release_factor = cfg_wdata;
          REG_SUSTAIN_LEVEL:  regs_shadow.sustain_level  = cfg_wdata;
          REG_RETRIG_MARGIN:  regs_shadow.retrig_margin  = cfg_wdata;
          REG_MODE_BITS:      regs_shadow.mode_bits      = cfg_wdata[MODE_W-1:0];
          default: ;
        endcase
      end
      if (tick.valid && tick.ready) begin
        advance_envelope(tick.gate_value, tick.trig_value, tick_result);
        envelope_due.push_back(tick_result);
      end
      if (env.valid && env.ready) begin
        if (envelope_due.size() == 0) begin
          report_mismatch($sformatf("result transaction level 0x%0h stage %0d with none pending",
                                    env.level, env.stage));
        end else begin
          oldest = envelope_due.pop_front();
          compared_tally++;
          if (env.level !== oldest.level)
            report_mismatch($sformatf("result %0d level got 0x%0h want 0x%0h",
                                      compared_tally, env.level, oldest.level));
          if (env.stage !== oldest.stage)
            report_mismatch($sformatf("result %0d stage got %0d want %0d (%s)",
                                      compared_tally, env.stage, oldest.stage,
                                      oldest.stage.name()));
        end
      end
    end
    mismatch_count <= fail_tally;
    pending_count  <= envelope_due.size();
    compared_count <= compared_tally;
  end

endmodule

@@ bench/hold_attack_decay_release_envelope_core_test.sv @@
// Top of the envelope core bench: clock, reset, register programming and tick stimulus.
// Depends on hadre_pkg, both channel interfaces, the core and hadre_envelope_checker.
`timescale 1ns / 1ps

module hold_attack_decay_release_envelope_core_test;
  import hadre_pkg::*;

  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 215;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ONE_I        = 1 << FRAC_BITS;
  localparam int REG_MAX_I    = (1 << Q_W) - 1;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0]       cfg_wdata = '0;

  int mismatch_count;
  int pending_count;
  int compared_count;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  logic [GATE_W-1:0] cur_gate = '0;
  logic [TRIG_W-1:0] cur_trig = '0;

  hadre_tick_if tick ();
  hadre_env_if  env ();

  hold_attack_decay_release_envelope_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tick      (tick),
    .env       (env)
  );

  hadre_envelope_checker envelope_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .tick           (tick),
    .env            (env),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .compared_count (compared_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hold_attack_decay_release_envelope_core_test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      env.ready <= 1'b0;
    end else begin
      env.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic send_tick(input logic [GATE_W-1:0] g, input logic [TRIG_W-1:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      tick.valid <= 1'b0;
      @(posedge clk);
    end
    tick.valid      <= 1'b1;
    tick.gate_value <= g;
    tick.trig_value <= t;
    do @(posedge clk); while (!tick.ready);
    cur_gate = g;
    cur_trig = t;
    ticks_sent++;
  endtask

  // drop valid and hold until every predicted result has been taken
  task automatic settle();
    tick.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [Q_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all(input logic [Q_W-1:0] hs, input logic [Q_W-1:0] as_step,
                           input logic [Q_W-1:0] b1, input logic [Q_W-1:0] rel,
                           input logic [Q_W-1:0] sus, input logic [Q_W-1:0] margin,
                           input logic [MODE_W-1:0] mode);
    write_reg(REG_HOLD_STEP, hs);
    write_reg(REG_ATTACK_STEP, as_step);
    write_reg(REG_DECAY_FACTOR, b1);
    write_reg(REG_RELEASE_FACTOR, rel);
    write_reg(REG_SUSTAIN_LEVEL, sus);
    write_reg(REG_RETRIG_MARGIN, margin);
    write_reg(REG_MODE_BITS, Q_W'(mode));
    settings_used++;
  endtask

  function automatic logic [Q_W-1:0] pick_step();
    case ($urandom_range(9))
      0:       return '0;
      1:       return Q_W'(REG_MAX_I);
      2:       return Q_ONE;
      default: return Q_W'((ONE_I >> $urandom_range(4)) + $urandom_range(4095));
    endcase
  endfunction

  function automatic logic [Q_W-1:0] pick_factor();
    case ($urandom_range(9))
      0:          return '0;
      1:          return Q_ONE;
      2:          return Q_W'(REG_MAX_I);
      3:          return Q_W'(ONE_I + $urandom_range(ONE_I - 1, 1));
      4, 5, 6:    return Q_W'($urandom_range(ONE_I - 1, (ONE_I / 4) * 3));
      default:    return Q_W'($urandom_range(ONE_I));
    endcase
  endfunction

  // mostly held gate and trigger with occasional edges, plus some noise ticks
  task automatic run_phase(input int n, input bit pause_mid);
    int                i;
    int                r;
    logic [GATE_W-1:0] g;
    logic [TRIG_W-1:0] t;
    for (i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) settle();
      g = cur_gate;
      t = cur_trig;
      r = $urandom_range(99);
      if (r < 4) begin
        g = GATE_W'($urandom_range(255));
        t = TRIG_W'($urandom_range(255));
      end else if (r < 12) begin
        g = (cur_gate != '0 && $urandom_range(1)) ? '0 : GATE_W'($urandom_range(255, 1));
      end else if (r < 18) begin
        t = TRIG_W'($urandom_range(255));
      end
      send_tick(g, t);
    end
  endtask

  initial begin
    int ph;
    tick.valid      = 1'b0;
    tick.gate_value = '0;
    tick.trig_value = '0;
    env.ready       = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 20;
    sink_idle_pct = 69;

    // reset settings: two-tick hold, two-tick attack, instant decay to one half
    send_tick(8'd0, 8'd0);
    send_tick(8'd255, 8'd0);
    send_tick(8'd255, 8'd0);
    send_tick(8'd255, 8'd0);
    send_tick(8'd255, 8'd0);
    send_tick(8'd255, 8'd0);
    send_tick(8'd255, 8'd255);
    send_tick(8'd1, 8'd255);
    send_tick(8'd0, 8'd255);
    settle();

    // saturating registers, looping and trigger restart
    write_all(Q_W'(REG_MAX_I), Q_W'(ONE_I >> 2), Q_W'((ONE_I >> 2) * 3), Q_W'(ONE_I >> 1),
              Q_HALF, Q_W'(REG_MAX_I), 2'd3);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd0);
    send_tick(8'd128, 8'd1);
    send_tick(8'd128, 8'd1);
    send_tick(8'd0, 8'd2);
    send_tick(8'd0, 8'd2);
    settle();

    write_all('0, '0, '0, '0, '0, '0, 2'd0);
    send_tick(8'd255, 8'd170);
    send_tick(8'd255, 8'd85);
    send_tick(8'd255, 8'd85);
    send_tick(8'd0, 8'd85);

    for (ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 2) begin
        src_idle_pct  = 69;
        sink_idle_pct = 20;
      end else if (ph == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (ph == 0)
        write_all(Q_W'(REG_MAX_I), Q_W'(REG_MAX_I), Q_W'(REG_MAX_I), Q_W'(REG_MAX_I),
                  Q_W'(REG_MAX_I), Q_W'(REG_MAX_I), 2'd3);
      else if (ph == 3)
        write_all('0, Q_W'(ONE_I >> 3), '0, '0, '0, '0, 2'd1);
      else
        write_all(pick_step(), pick_step(), pick_factor(), pick_factor(), pick_factor(),
                  pick_factor(), MODE_W'($urandom_range(3)));
      run_phase(PHASE_ITEMS, ph == 1);
    end

    settle();
    $display("Covered %0d ticks under %0d register settings; %0d results compared.",
             ticks_sent, settings_used + 1, compared_count);
    $display("Gate and trigger edges, saturated and zero registers, looping and restarts.");
    if (mismatch_count == 0) begin
      $display("hold_attack_decay_release_envelope_core_test passed");
    end else begin
      $display("hold_attack_decay_release_envelope_core_test failed");
    end
    $finish;
  end

endmodule
